/* sv/scene_color_fade_sequencer_defines.svh */
// ----------------------------------------------------------------------------
// scene colour fade sequencer assertion macros
// shared concurrent assertion forms, clocked on aclk, held off during reset
// ----------------------------------------------------------------------------
`ifndef SCENE_COLOR_FADE_SEQUENCER_DEFINES_SVH
`define SCENE_COLOR_FADE_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define SCF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("scf assertion failed");

// next-cycle implication
`define SCF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("scf assertion failed");

`endif

/* sv/scf_pkg.sv */
// ----------------------------------------------------------------------------
// scf_pkg
// types, constants and the power-up scene list of the scene colour fader
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scf_pkg;

    localparam int MAX_SCENES = 16;
    localparam int IDX_W      = $clog2(MAX_SCENES);
    localparam int SCENE_W    = $clog2(MAX_SCENES + 1);
    localparam int COL_W      = 8;
    localparam int DUR_W      = 32;
    localparam int PROD_W     = COL_W + DUR_W;
    localparam int NUM_CH     = 3;

    localparam logic [SCENE_W-1:0] COUNT_RESET = SCENE_W'(11);

    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_WRITE   = 2'd1,
        REQ_RESTART = 2'd2,
        REQ_UNUSED  = 2'd3
    } req_t;

    // channel 0 red, 1 green, 2 blue
    typedef struct packed {
        logic [NUM_CH-1:0][COL_W-1:0] s;
        logic [NUM_CH-1:0][COL_W-1:0] e;
        logic [DUR_W-1:0]             dur;
    } scene_t;

    function automatic scene_t mk_scene(
        input logic [7:0] sr, input logic [7:0] sg, input logic [7:0] sb,
        input logic [7:0] er, input logic [7:0] eg, input logic [7:0] eb,
        input logic [31:0] d
    );
        scene_t sc;
        sc.s   = {sb, sg, sr};
        sc.e   = {eb, eg, er};
        sc.dur = d;
        return sc;
    endfunction

    // table contents after reset
    function automatic scene_t boot_scene(input logic [IDX_W-1:0] idx);
        scene_t sc;
        sc = '0;
        case (idx)
            4'd0:    sc = mk_scene(125, 125, 125, 125, 125, 125, 32'd1900);
            4'd1:    sc = mk_scene(125, 125, 125, 255, 128,   0, 32'd1450);
            4'd2:    sc = mk_scene(255, 128,   0, 125, 125, 125, 32'd1316);
            4'd3:    sc = mk_scene(125, 125, 125, 125, 125, 125, 32'd14116);
            4'd4:    sc = mk_scene(125, 125, 125, 255,  32,   0, 32'd616);
            4'd5:    sc = mk_scene(255,  32,   0, 125, 125, 125, 32'd616);
            4'd6:    sc = mk_scene(125, 125, 125, 125, 125, 125, 32'd27766);
            4'd7:    sc = mk_scene(125, 125, 125, 255, 128,   0, 32'd1666);
            4'd8:    sc = mk_scene(255, 128,   0, 255, 128,   0, 32'd12266);
            4'd9:    sc = mk_scene(255, 128,   0, 255, 255, 255, 32'd1666);
            4'd10:   sc = mk_scene(255, 255, 255, 255, 255, 255, 32'd251016);
            default: sc = '0;
        endcase
        return sc;
    endfunction

endpackage

/* sv/scene_color_fade_sequencer.sv */
// ----------------------------------------------------------------------------
// scene_color_fade_sequencer
// timed scene player: linear rgb fade between keyframes held in a scene table
// ----------------------------------------------------------------------------
// Input words (s_*) are ticks, scene table writes or restarts. A tick returns
// one result word (m_*): the colour for all pixels, the scene number after the
// tick and a show-over flag; writes, restarts and unused codes return nothing.
// The scene count register is written on cfg_* and is read by ticks.
// The block works on one word at a time; s_ready is high only while it idles.
// Writes and restarts are done in the idle state. A tick reads the scene table
// (registered memory read), then either finishes at once (scene ends, or show
// over) or fades each channel through one 8x32 multiplier and an 8-step
// restoring divider shared by the three channels.
// Reset loads the built-in eleven scenes (entries not yet written read back the
// power-up list), scene count 11, scene 0 and time base 0; no clearing pass.
// The result sits in an output register: a new word is taken while it waits,
// and a finished tick holds until m_ready frees the register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "scene_color_fade_sequencer_defines.svh"

module scene_color_fade_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    // scene count register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [31:0] s_now_ms,
    input  logic [3:0]  s_scene_index,
    input  logic [7:0]  s_start_red,
    input  logic [7:0]  s_start_green,
    input  logic [7:0]  s_start_blue,
    input  logic [7:0]  s_end_red,
    input  logic [7:0]  s_end_green,
    input  logic [7:0]  s_end_blue,
    input  logic [31:0] s_duration_ms,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,
    output logic [4:0]  m_scene_now,
    output logic        m_show_over
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

    localparam int IDX_W   = scf_pkg::IDX_W;
    localparam int SCENE_W = scf_pkg::SCENE_W;
    localparam int COL_W   = scf_pkg::COL_W;
    localparam int DUR_W   = scf_pkg::DUR_W;
    localparam int PROD_W  = scf_pkg::PROD_W;
    localparam int NUM_CH  = scf_pkg::NUM_CH;
    localparam int CNT_W   = $clog2(COL_W);
    localparam int CH_W    = $clog2(NUM_CH);

    localparam logic [COL_W-1:0]   WHITE   = '1;
    localparam logic [SCENE_W-1:0] MAX_CNT = SCENE_W'(scf_pkg::MAX_SCENES);

    // ------------------------------------------------------------------------
    // scene table memory
    // ------------------------------------------------------------------------
    scf_pkg::scene_t mem [scf_pkg::MAX_SCENES];
    scf_pkg::scene_t rd_data_reg;
    scf_pkg::scene_t wr_entry;
    logic [scf_pkg::MAX_SCENES-1:0] written_reg;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] rd_addr_reg;
    logic             rd_hit_reg;
    logic             mem_we;

    state_t state_reg;

    logic [SCENE_W-1:0] count_reg;
    logic [SCENE_W-1:0] cur_scene_reg;
    logic [DUR_W-1:0]   time_base_reg;
    logic [DUR_W-1:0]   now_reg;
    logic [DUR_W-1:0]   elapsed_reg;
    scf_pkg::scene_t    ent_reg;
    logic [CH_W-1:0]    ch_reg;
    logic [CNT_W-1:0]   bit_cnt_reg;
    logic [DUR_W-1:0]   rem_reg;
    logic [COL_W-1:0]   low_reg;
    logic [COL_W-1:0]   quo_reg;
    logic [NUM_CH-1:0][COL_W-1:0] col_reg;
    logic [SCENE_W-1:0] res_scene_reg;
    logic               res_over_reg;

    logic               m_valid_reg;
    logic [COL_W-1:0]   m_red_reg;
    logic [COL_W-1:0]   m_green_reg;
    logic [COL_W-1:0]   m_blue_reg;
    logic [SCENE_W-1:0] m_scene_reg;
    logic               m_over_reg;

    logic in_fire;
    logic out_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign rd_addr = cur_scene_reg[IDX_W-1:0];
    assign mem_we  = in_fire && (s_req_type == scf_pkg::REQ_WRITE);

    always_comb begin
        wr_entry.s   = {s_start_blue, s_start_green, s_start_red};
        wr_entry.e   = {s_end_blue, s_end_green, s_end_red};
        wr_entry.dur = s_duration_ms;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[s_scene_index] <= wr_entry;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // entries never written read back the power-up scene list
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
        end else if (mem_we) begin
            written_reg[s_scene_index] <= 1'b1;
        end
        rd_addr_reg <= rd_addr;
        rd_hit_reg  <= written_reg[rd_addr];
    end

    // ------------------------------------------------------------------------
    // tick datapath
    // ------------------------------------------------------------------------
    scf_pkg::scene_t    entry;
    logic [SCENE_W-1:0] count_eff;
    logic [DUR_W-1:0]   elapsed;
    logic               scene_done;
    logic [SCENE_W-1:0] cur_inc;
    logic [DUR_W-1:0]   time_base_next;

    assign entry          = rd_hit_reg ? rd_data_reg : scf_pkg::boot_scene(rd_addr_reg);
    assign count_eff      = (count_reg > MAX_CNT) ? MAX_CNT : count_reg;
    assign elapsed        = now_reg - time_base_reg;
    assign scene_done     = (elapsed >= entry.dur);
    assign cur_inc        = cur_scene_reg + SCENE_W'(1);
    assign time_base_next = time_base_reg + entry.dur;

    logic [COL_W-1:0]  ch_s;
    logic [COL_W-1:0]  ch_e;
    logic              ch_up;
    logic [COL_W-1:0]  mag;
    logic [PROD_W-1:0] prod;

    assign ch_s  = ent_reg.s[ch_reg];
    assign ch_e  = ent_reg.e[ch_reg];
    assign ch_up = (ch_e >= ch_s);
    assign mag   = ch_up ? (ch_e - ch_s) : (ch_s - ch_e);
    assign prod  = PROD_W'(mag) * PROD_W'(elapsed_reg);

    // restoring divide step; the partial remainder stays below the duration
    logic [DUR_W:0]   trial;
    logic [DUR_W:0]   diff;
    logic             q_bit;
    logic [DUR_W-1:0] rem_next;
    logic [COL_W-1:0] quo_next;
    logic [COL_W-1:0] fade_col;

    assign trial    = {rem_reg, low_reg[COL_W-1]};
    assign diff     = trial - {1'b0, ent_reg.dur};
    assign q_bit    = (trial >= {1'b0, ent_reg.dur});
    assign rem_next = q_bit ? diff[DUR_W-1:0] : trial[DUR_W-1:0];
    assign quo_next = {quo_reg[COL_W-2:0], q_bit};
    assign fade_col = ch_up ? (ch_s + quo_next) : (ch_s - quo_next);

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= scf_pkg::COUNT_RESET;
            cur_scene_reg <= '0;
            time_base_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                count_reg <= cfg_data;
            end
            // in ST_OUT the next word takes the register over
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        case (s_req_type)
                            scf_pkg::REQ_TICK: begin
                                now_reg   <= s_now_ms;
                                state_reg <= ST_LOAD;
                            end
                            scf_pkg::REQ_RESTART: begin
                                cur_scene_reg <= '0;
                                time_base_reg <= '0;
                            end
                            default: ;
                        endcase
                    end
                end

                ST_LOAD: begin
                    if (cur_scene_reg >= count_eff) begin
                        col_reg       <= {NUM_CH{WHITE}};
                        res_scene_reg <= cur_scene_reg;
                        res_over_reg  <= 1'b1;
                        state_reg     <= ST_OUT;
                    end else if (scene_done) begin
                        time_base_reg <= time_base_next;
                        cur_scene_reg <= cur_inc;
                        res_scene_reg <= cur_inc;
                        if (cur_inc >= count_eff) begin
                            col_reg      <= {NUM_CH{WHITE}};
                            res_over_reg <= 1'b1;
                        end else begin
                            col_reg      <= entry.e;
                            res_over_reg <= 1'b0;
                        end
                        state_reg <= ST_OUT;
                    end else begin
                        ent_reg       <= entry;
                        elapsed_reg   <= elapsed;
                        res_scene_reg <= cur_scene_reg;
                        res_over_reg  <= 1'b0;
                        ch_reg        <= '0;
                        state_reg     <= ST_MUL;
                    end
                end

                ST_MUL: begin
                    // the quotient is below 256, so the top bits start as remainder
                    rem_reg     <= prod[PROD_W-1:COL_W];
                    low_reg     <= prod[COL_W-1:0];
                    quo_reg     <= '0;
                    bit_cnt_reg <= '0;
                    state_reg   <= ST_DIV;
                end

                ST_DIV: begin
                    rem_reg     <= rem_next;
                    low_reg     <= {low_reg[COL_W-2:0], 1'b0};
                    quo_reg     <= quo_next;
                    bit_cnt_reg <= bit_cnt_reg + CNT_W'(1);
                    if (bit_cnt_reg == CNT_W'(COL_W - 1)) begin
                        col_reg[ch_reg] <= fade_col;
                        if (ch_reg == CH_W'(NUM_CH - 1)) begin
                            state_reg <= ST_OUT;
                        end else begin
                            ch_reg    <= ch_reg + CH_W'(1);
                            state_reg <= ST_MUL;
                        end
                    end
                end

                ST_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_red_reg   <= col_reg[0];
                        m_green_reg <= col_reg[1];
                        m_blue_reg  <= col_reg[2];
                        m_scene_reg <= res_scene_reg;
                        m_over_reg  <= res_over_reg;
                        state_reg   <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_red       = m_red_reg;
    assign m_green     = m_green_reg;
    assign m_blue      = m_blue_reg;
    assign m_scene_now = m_scene_reg;
    assign m_show_over = m_over_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `SCF_ASSERT_SAME(a_div_rem_below_dur, state_reg == ST_DIV, rem_reg < ent_reg.dur)
    `SCF_ASSERT_SAME(a_over_is_white, m_valid_reg && m_over_reg,
        m_red_reg == WHITE && m_green_reg == WHITE && m_blue_reg == WHITE)
    `SCF_ASSERT_SAME(a_scene_in_range, m_valid_reg, m_scene_reg <= MAX_CNT)
    `SCF_ASSERT_NEXT(a_result_only_from_out, !m_valid_reg && state_reg != ST_OUT,
        !m_valid_reg)

endmodule
